### rtl/core/psd_pkg.sv
// Shared types, widths and helpers for the point-to-segment squared distance block
package psd_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int LEN_W       = PROD_W;
    localparam int DOT_W       = PROD_W + 1;
    localparam int NUM_W       = DOT_W + DIFF_W;
    localparam int MAG_W       = NUM_W - 1;
    localparam int QUO_W       = COORD_WIDTH + 4;
    localparam int FOOT_W      = QUO_W + 1;
    localparam int FD_W        = FOOT_W + 1;
    localparam int SQ_W        = 2 * FD_W;
    localparam int TRIAL_W     = LEN_W + QUO_W;
    localparam int DIST_W      = 33;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;
    localparam int FIFO_CW     = FIFO_AW + 1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;

    typedef enum logic [1:0] {
        KIND_VERT,
        KIND_HORZ,
        KIND_GEN
    } psd_kind_t;

    // classified item handed from front to back
    typedef struct packed {
        coord_t    ax;
        coord_t    ay;
        coord_t    bx;
        coord_t    by;
        coord_t    cx;
        coord_t    cy;
        diff_t     dx;
        diff_t     dy;
        diff_t     ex;
        diff_t     ey;
        diff_t     fx;
        diff_t     fy;
        psd_kind_t kind;
        logic      axis_span;
    } psd_item_t;

    // context carried alongside the divider
    typedef struct packed {
        psd_kind_t         kind;
        logic              axis_span;
        coord_t            ax;
        coord_t            bx;
        coord_t            cx;
        coord_t            cy;
        logic [DIST_W-1:0] dist_end;
        logic [DIST_W-1:0] dist_axis;
        logic              neg_x;
        logic              neg_y;
    } psd_ctx_t;

    // v in the half-open span between a and b
    function automatic logic span_has(input logic signed [FOOT_W-1:0] a,
                                      input logic signed [FOOT_W-1:0] v,
                                      input logic signed [FOOT_W-1:0] b);
        return ((a >= v) && (v > b)) || ((b >= v) && (v > a));
    endfunction

endpackage

### rtl/core/psd_front.sv
// Front end: takes items, forms differences and classifies the segment
module psd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  psd_pkg::coord_t   ax,
    input  psd_pkg::coord_t   ay,
    input  psd_pkg::coord_t   bx,
    input  psd_pkg::coord_t   by,
    input  psd_pkg::coord_t   cx,
    input  psd_pkg::coord_t   cy,
    output psd_pkg::psd_item_t item,
    output logic              item_valid,
    input  logic              item_ready
);
    import psd_pkg::*;

    logic      valid_reg;
    psd_item_t item_reg;
    psd_item_t item_next;
    logic      take;

    // accept when the holding register is empty or leaving
    assign full       = valid_reg && !item_ready;
    assign take       = push && !full;
    assign item       = item_reg;
    assign item_valid = valid_reg;

    // differences and classification
    always_comb
    begin
        item_next.ax = ax;
        item_next.ay = ay;
        item_next.bx = bx;
        item_next.by = by;
        item_next.cx = cx;
        item_next.cy = cy;
        item_next.dx = DIFF_W'(bx) - DIFF_W'(ax);
        item_next.dy = DIFF_W'(by) - DIFF_W'(ay);
        item_next.ex = DIFF_W'(cx) - DIFF_W'(ax);
        item_next.ey = DIFF_W'(cy) - DIFF_W'(ay);
        item_next.fx = DIFF_W'(cx) - DIFF_W'(bx);
        item_next.fy = DIFF_W'(cy) - DIFF_W'(by);
        if (ax == bx)
        begin
            item_next.kind      = KIND_VERT;
            item_next.axis_span = span_has(FOOT_W'(ay), FOOT_W'(cy), FOOT_W'(by));
        end
        else if (ay == by)
        begin
            item_next.kind      = KIND_HORZ;
            item_next.axis_span = span_has(FOOT_W'(ax), FOOT_W'(cx), FOOT_W'(bx));
        end
        else
        begin
            item_next.kind      = KIND_GEN;
            item_next.axis_span = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (take)
            valid_reg <= 1'b1;
        else if (item_ready)
            valid_reg <= 1'b0;
    end

    // item register
    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_next;
    end

endmodule

### rtl/core/psd_fifo.sv
// Short queue of classified items between front and back
module psd_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  psd_pkg::psd_item_t wr_item,
    output logic               fifo_full,
    input  logic               rd_en,
    output psd_pkg::psd_item_t rd_item,
    output logic               fifo_empty
);
    import psd_pkg::*;

    psd_item_t          mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;

    assign fifo_full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign fifo_empty = (count_reg == '0);
    assign rd_item    = mem[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_item;
    end

`ifndef SYNTHESIS
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("queue count beyond depth");
    a_fifo_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !fifo_empty)
        else $error("queue read while empty");
`endif

endmodule

### rtl/core/psd_div.sv
// Pipelined restoring divider, two numerators over one divisor, one quotient bit a stage
module psd_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [psd_pkg::MAG_W-1:0]   in_mag_x,
    input  logic [psd_pkg::MAG_W-1:0]   in_mag_y,
    input  logic [psd_pkg::LEN_W-1:0]   in_len,
    input  psd_pkg::psd_ctx_t           in_ctx,
    output logic                        out_valid,
    output logic [psd_pkg::QUO_W-1:0]   out_q_x,
    output logic [psd_pkg::QUO_W-1:0]   out_q_y,
    output psd_pkg::psd_ctx_t           out_ctx
);
    import psd_pkg::*;

    logic             valid_reg [QUO_W];
    logic [MAG_W-1:0] rem_x_reg [QUO_W];
    logic [MAG_W-1:0] rem_y_reg [QUO_W];
    logic [QUO_W-1:0] q_x_reg   [QUO_W];
    logic [QUO_W-1:0] q_y_reg   [QUO_W];
    logic [LEN_W-1:0] len_reg   [QUO_W];
    psd_ctx_t         ctx_reg   [QUO_W];

    logic             src_valid [QUO_W];
    logic [MAG_W-1:0] src_rem_x [QUO_W];
    logic [MAG_W-1:0] src_rem_y [QUO_W];
    logic [QUO_W-1:0] src_q_x   [QUO_W];
    logic [QUO_W-1:0] src_q_y   [QUO_W];
    logic [LEN_W-1:0] src_len   [QUO_W];
    psd_ctx_t         src_ctx   [QUO_W];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        localparam int BIT = QUO_W - 1 - k;

        logic [TRIAL_W-1:0] dsh;
        logic [TRIAL_W-1:0] rx_ext;
        logic [TRIAL_W-1:0] ry_ext;
        logic               ge_x;
        logic               ge_y;

        // stage source: inputs for the first stage, previous stage otherwise
        if (k == 0)
        begin : g_first
            assign src_valid[k] = in_valid;
            assign src_rem_x[k] = in_mag_x;
            assign src_rem_y[k] = in_mag_y;
            assign src_q_x[k]   = '0;
            assign src_q_y[k]   = '0;
            assign src_len[k]   = in_len;
            assign src_ctx[k]   = in_ctx;
        end
        else
        begin : g_next
            assign src_valid[k] = valid_reg[k-1];
            assign src_rem_x[k] = rem_x_reg[k-1];
            assign src_rem_y[k] = rem_y_reg[k-1];
            assign src_q_x[k]   = q_x_reg[k-1];
            assign src_q_y[k]   = q_y_reg[k-1];
            assign src_len[k]   = len_reg[k-1];
            assign src_ctx[k]   = ctx_reg[k-1];
        end

        // trial subtraction of the shifted divisor
        assign dsh    = TRIAL_W'(src_len[k]) << BIT;
        assign rx_ext = TRIAL_W'(src_rem_x[k]);
        assign ry_ext = TRIAL_W'(src_rem_y[k]);
        assign ge_x   = (rx_ext >= dsh);
        assign ge_y   = (ry_ext >= dsh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= src_valid[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_x_reg[k] <= ge_x ? MAG_W'(rx_ext - dsh) : src_rem_x[k];
                rem_y_reg[k] <= ge_y ? MAG_W'(ry_ext - dsh) : src_rem_y[k];
                q_x_reg[k]   <= src_q_x[k] | (QUO_W'(ge_x) << BIT);
                q_y_reg[k]   <= src_q_y[k] | (QUO_W'(ge_y) << BIT);
                len_reg[k]   <= src_len[k];
                ctx_reg[k]   <= src_ctx[k];
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_q_x   = q_x_reg[QUO_W-1];
    assign out_q_y   = q_y_reg[QUO_W-1];
    assign out_ctx   = ctx_reg[QUO_W-1];

endmodule

### rtl/core/psd_back.sv
// Back end: products, foot of the perpendicular, final selection and result register
module psd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  psd_pkg::psd_item_t          item,
    input  logic                        item_valid,
    output logic                        item_take,
    input  logic                        pop,
    output logic                        empty,
    output logic [psd_pkg::DIST_W-1:0]  dist_sq,
    output logic                        on_segment
);
    import psd_pkg::*;

    logic en;

    logic                     s1_valid_reg;
    psd_item_t                s1_item_reg;
    logic signed [PROD_W-1:0] s1_dxdx_reg, s1_dydy_reg, s1_exdx_reg, s1_eydy_reg;
    logic signed [PROD_W-1:0] s1_exex_reg, s1_eyey_reg, s1_fxfx_reg, s1_fyfy_reg;

    logic                     s2_valid_reg;
    psd_item_t                s2_item_reg;
    logic [LEN_W-1:0]         s2_len_reg, s2_da_reg, s2_db_reg;
    logic signed [DOT_W-1:0]  s2_dot_reg;
    logic [DIST_W-1:0]        s2_dax_reg, s2_day_reg;

    logic                     s3_valid_reg;
    psd_ctx_t                 s3_ctx_reg;
    logic [LEN_W-1:0]         s3_len_reg;
    logic signed [NUM_W-1:0]  s3_mx_reg, s3_mdx_reg, s3_my_reg, s3_mdy_reg;

    logic                     s4_valid_reg;
    psd_ctx_t                 s4_ctx_reg;
    logic [LEN_W-1:0]         s4_len_reg;
    logic signed [NUM_W-1:0]  s4_nx_reg, s4_ny_reg;

    logic                     s5_valid_reg;
    psd_ctx_t                 s5_ctx_reg;
    psd_ctx_t                 s5_ctx_next;
    logic [LEN_W-1:0]         s5_len_reg;
    logic [MAG_W-1:0]         s5_mx_reg, s5_my_reg;

    logic                     dv_valid;
    logic [QUO_W-1:0]         dv_q_x, dv_q_y;
    psd_ctx_t                 dv_ctx;

    logic signed [FOOT_W-1:0] ix, iy;
    logic                     s6_valid_reg;
    psd_ctx_t                 s6_ctx_reg;
    logic signed [FD_W-1:0]   s6_fdx_reg, s6_fdy_reg;
    logic                     s6_on_reg;

    logic                     s7_valid_reg;
    psd_ctx_t                 s7_ctx_reg;
    logic signed [SQ_W-1:0]   s7_sqx_reg, s7_sqy_reg;
    logic                     s7_on_reg;

    logic                     out_valid_reg;
    logic [DIST_W-1:0]        out_dist_reg;
    logic                     out_on_reg;
    logic [DIST_W-1:0]        dist_next;
    logic                     on_next;

    // whole back pipe moves unless a result waits untaken
    assign en        = !out_valid_reg || pop;
    assign item_take = en && item_valid;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= item_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= dv_valid;
            s7_valid_reg  <= s6_valid_reg;
            out_valid_reg <= s7_valid_reg;
        end
    end

    // stage 1: difference products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_item_reg <= item;
            s1_dxdx_reg <= item.dx * item.dx;
            s1_dydy_reg <= item.dy * item.dy;
            s1_exdx_reg <= item.ex * item.dx;
            s1_eydy_reg <= item.ey * item.dy;
            s1_exex_reg <= item.ex * item.ex;
            s1_eyey_reg <= item.ey * item.ey;
            s1_fxfx_reg <= item.fx * item.fx;
            s1_fyfy_reg <= item.fy * item.fy;
        end
    end

    // stage 2: length, dot product and endpoint distances
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_item_reg <= s1_item_reg;
            s2_len_reg  <= LEN_W'($unsigned(s1_dxdx_reg)) + LEN_W'($unsigned(s1_dydy_reg));
            s2_dot_reg  <= DOT_W'(s1_exdx_reg) + DOT_W'(s1_eydy_reg);
            s2_da_reg   <= LEN_W'($unsigned(s1_exex_reg)) + LEN_W'($unsigned(s1_eyey_reg));
            s2_db_reg   <= LEN_W'($unsigned(s1_fxfx_reg)) + LEN_W'($unsigned(s1_fyfy_reg));
            s2_dax_reg  <= s1_exex_reg[DIST_W-1:0];
            s2_day_reg  <= s1_eyey_reg[DIST_W-1:0];
        end
    end

    // stage 3: numerator products, nearest endpoint, axis distance
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_ctx_reg.kind      <= s2_item_reg.kind;
            s3_ctx_reg.axis_span <= s2_item_reg.axis_span;
            s3_ctx_reg.ax        <= s2_item_reg.ax;
            s3_ctx_reg.bx        <= s2_item_reg.bx;
            s3_ctx_reg.cx        <= s2_item_reg.cx;
            s3_ctx_reg.cy        <= s2_item_reg.cy;
            s3_ctx_reg.dist_end  <= (s2_da_reg < s2_db_reg) ? s2_da_reg[DIST_W-1:0]
                                                           : s2_db_reg[DIST_W-1:0];
            s3_ctx_reg.dist_axis <= (s2_item_reg.kind == KIND_VERT) ? s2_dax_reg : s2_day_reg;
            s3_ctx_reg.neg_x     <= 1'b0;
            s3_ctx_reg.neg_y     <= 1'b0;
            s3_len_reg           <= s2_len_reg;
            s3_mx_reg            <= s2_item_reg.ax * $signed({1'b0, s2_len_reg});
            s3_my_reg            <= s2_item_reg.ay * $signed({1'b0, s2_len_reg});
            s3_mdx_reg           <= s2_dot_reg * s2_item_reg.dx;
            s3_mdy_reg           <= s2_dot_reg * s2_item_reg.dy;
        end
    end

    // stage 4: numerators of the foot
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_ctx_reg <= s3_ctx_reg;
            s4_len_reg <= s3_len_reg;
            s4_nx_reg  <= s3_mx_reg + s3_mdx_reg;
            s4_ny_reg  <= s3_my_reg + s3_mdy_reg;
        end
    end

    // numerator signs into the context
    always_comb
    begin
        s5_ctx_next       = s4_ctx_reg;
        s5_ctx_next.neg_x = s4_nx_reg[NUM_W-1];
        s5_ctx_next.neg_y = s4_ny_reg[NUM_W-1];
    end

    // stage 5: sign and magnitude for the divider
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_ctx_reg <= s5_ctx_next;
            s5_len_reg <= s4_len_reg;
            s5_mx_reg  <= s4_nx_reg[NUM_W-1] ? MAG_W'(-s4_nx_reg) : MAG_W'(s4_nx_reg);
            s5_my_reg  <= s4_ny_reg[NUM_W-1] ? MAG_W'(-s4_ny_reg) : MAG_W'(s4_ny_reg);
        end
    end

    psd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s5_valid_reg),
        .in_mag_x  (s5_mx_reg),
        .in_mag_y  (s5_my_reg),
        .in_len    (s5_len_reg),
        .in_ctx    (s5_ctx_reg),
        .out_valid (dv_valid),
        .out_q_x   (dv_q_x),
        .out_q_y   (dv_q_y),
        .out_ctx   (dv_ctx)
    );

    // signed foot, truncated toward zero
    assign ix = dv_ctx.neg_x ? -$signed({1'b0, dv_q_x}) : $signed({1'b0, dv_q_x});
    assign iy = dv_ctx.neg_y ? -$signed({1'b0, dv_q_y}) : $signed({1'b0, dv_q_y});

    // stage 6: offsets to the query point and span test
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_ctx_reg <= dv_ctx;
            s6_fdx_reg <= FD_W'(ix) - FD_W'(dv_ctx.cx);
            s6_fdy_reg <= FD_W'(iy) - FD_W'(dv_ctx.cy);
            s6_on_reg  <= span_has(FOOT_W'(dv_ctx.ax), ix, FOOT_W'(dv_ctx.bx));
        end
    end

    // stage 7: squares of the offsets
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_ctx_reg <= s6_ctx_reg;
            s7_sqx_reg <= s6_fdx_reg * s6_fdx_reg;
            s7_sqy_reg <= s6_fdy_reg * s6_fdy_reg;
            s7_on_reg  <= s6_on_reg;
        end
    end

    // final selection
    always_comb
    begin
        unique case (s7_ctx_reg.kind)
            KIND_VERT, KIND_HORZ:
            begin
                on_next   = s7_ctx_reg.axis_span;
                dist_next = s7_ctx_reg.axis_span ? s7_ctx_reg.dist_axis : s7_ctx_reg.dist_end;
            end
            KIND_GEN:
            begin
                on_next   = s7_on_reg;
                dist_next = s7_on_reg ? (DIST_W'(s7_sqx_reg) + DIST_W'(s7_sqy_reg))
                                      : s7_ctx_reg.dist_end;
            end
            default:
            begin
                on_next   = 1'b0;
                dist_next = s7_ctx_reg.dist_end;
            end
        endcase
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_dist_reg <= dist_next;
            out_on_reg   <= on_next;
        end
    end

    assign empty      = !out_valid_reg;
    assign dist_sq    = out_dist_reg;
    assign on_segment = out_on_reg;

`ifndef SYNTHESIS
    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        !en |-> out_valid_reg)
        else $error("back pipe stalled with no result waiting");
    a_stall_keeps_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !en) |=> s1_valid_reg)
        else $error("item lost from first back stage during stall");
`endif

endmodule

### rtl/core/point_segment_sq_distance.sv
// Throughput: one item per cycle unless a waiting result stalls the back; the 20-stage
// restoring divider (one quotient bit a stage) sets the depth of the back pipe.
// Front and back are split by a four-item queue; a full result register stalls the back.
// Reset: rst_n low clears all valid flags and queue pointers at once; data is not reset.
// Top level of the point-to-segment squared distance block
module point_segment_sq_distance (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  psd_pkg::coord_t             ax,
    input  psd_pkg::coord_t             ay,
    input  psd_pkg::coord_t             bx,
    input  psd_pkg::coord_t             by,
    input  psd_pkg::coord_t             cx,
    input  psd_pkg::coord_t             cy,
    output logic                        empty,
    input  logic                        pop,
    output logic [psd_pkg::DIST_W-1:0]  dist_sq,
    output logic                        on_segment
);
    import psd_pkg::*;

    psd_item_t front_item;
    logic      front_valid;
    logic      fifo_full;
    logic      fifo_empty;
    psd_item_t fifo_item;
    logic      back_take;

    // front end
    psd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .ax         (ax),
        .ay         (ay),
        .bx         (bx),
        .by         (by),
        .cx         (cx),
        .cy         (cy),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (!fifo_full)
    );

    // queue between front and back
    psd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (front_valid && !fifo_full),
        .wr_item    (front_item),
        .fifo_full  (fifo_full),
        .rd_en      (back_take),
        .rd_item    (fifo_item),
        .fifo_empty (fifo_empty)
    );

    // back end
    psd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (fifo_item),
        .item_valid (!fifo_empty),
        .item_take  (back_take),
        .pop        (pop),
        .empty      (empty),
        .dist_sq    (dist_sq),
        .on_segment (on_segment)
    );

endmodule
